// File: rtl/core/skyline_rectangle_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Skyline allocator assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SKYLINE_RECTANGLE_ALLOCATOR_CORE_ASSERT_SVH
`define SKYLINE_RECTANGLE_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTH

// Check a plain condition at every clock edge outside reset
`define SKRA_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("skra: assertion failed");

// Check that a condition implies another in the same cycle
`define SKRA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) \
        else $error("skra: implication failed");

`else

`define SKRA_ASSERT(label, prop)
`define SKRA_ASSERT_IMPL(label, ante, cons)

`endif

`endif

// File: rtl/core/skra_pkg.sv
// ----------------------------------------------------------------------------
// Skyline allocator package
// Shared types, codes and default sizes of the skyline rectangle allocator.
// ----------------------------------------------------------------------------
package skra_pkg;

    // Default page geometry and page count
    localparam int C_PAGE_WIDTH  = 128;
    localparam int C_PAGE_HEIGHT = 128;
    localparam int C_PAGE_LIMIT  = 128;

    // Operation codes of a request
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_BEGIN = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_PLACED  = 2'd0,
        STAT_NEWPAGE = 2'd1,
        STAT_NOFIT   = 2'd2,
        STAT_LIMIT   = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FWD,
        S_BWD,
        S_DEC,
        S_WR,
        S_CLR,
        S_OUT
    } t_state;

    // Request payload
    typedef struct packed {
        logic       operation;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
    } t_alloc_req;

    // Response payload
    typedef struct packed {
        t_status    status;
        logic [6:0] pos_x;
        logic [6:0] pos_y;
        logic [6:0] page_index;
    } t_alloc_rsp;

endpackage

// File: rtl/core/skra_stream_if.sv
// ----------------------------------------------------------------------------
// Skyline allocator stream interface
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface skra_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/skyline_rectangle_allocator_core.sv
// ----------------------------------------------------------------------------
// Skyline rectangle allocator core
// Bottom-left skyline packer of rectangles into square pages.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per transfer: an allocate (width, height) or a
//   begin, which clears the column profile and the page counter. o_rsp
//   returns exactly one response per request: status, x, y and page.
//   A request is taken only while the sequencer is idle; one request is
//   worked on at a time. A response waits in an output register, so the
//   next request is taken while o_rsp is stalled.
//   The order of work is set by the single read port of the column memory:
//   one forward pass builds block prefix maxima, one backward pass builds
//   suffix maxima and picks the start, then the chosen columns are written
//   back. Reset runs a clearing pass over the whole column memory; no
//   request is taken until it ends. A stalled receiver holds the response
//   and stops only the completion of the following request.
// ----------------------------------------------------------------------------
`include "skyline_rectangle_allocator_core_assert.svh"

module skyline_rectangle_allocator_core
    import skra_pkg::*;
#(
    parameter int PAGE_WIDTH  = C_PAGE_WIDTH,
    parameter int PAGE_HEIGHT = C_PAGE_HEIGHT,
    parameter int PAGE_LIMIT  = C_PAGE_LIMIT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    skra_stream_if.sink   i_req,
    skra_stream_if.source o_rsp
);

    localparam int AW  = (PAGE_WIDTH > 1) ? $clog2(PAGE_WIDTH) : 1;
    localparam int HW  = $clog2(PAGE_HEIGHT + 1);
    localparam int PGW = ($clog2(PAGE_LIMIT) > 7) ? $clog2(PAGE_LIMIT) : 7;
    localparam logic [AW-1:0] LAST_IDX = AW'(PAGE_WIDTH - 1);

    // Sequencer and datapath registers
    t_state          r_state, n_state;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_iss, n_iss;
    logic            r_dv, n_dv;
    logic [AW-1:0]   r_didx, n_didx;
    logic [7:0]      r_c, n_c;
    logic            r_first, n_first;
    logic [HW-1:0]   r_run, n_run;
    logic [HW-1:0]   r_best, n_best;
    logic [AW-1:0]   r_bx, n_bx;
    logic            r_found, n_found;
    logic [7:0]      r_w, n_w;
    logic [7:0]      r_h, n_h;
    logic [HW-1:0]   r_wval, n_wval;
    logic [7:0]      r_cnt, n_cnt;
    logic [PGW-1:0]  r_page, n_page;
    logic            r_clr_newpage, n_clr_newpage;
    logic            r_clr_out, n_clr_out;
    t_alloc_rsp      r_res, n_res;
    logic            r_ovld, n_ovld;
    t_alloc_rsp      r_odata, n_odata;

    // Column profile and block prefix memories
    logic [HW-1:0]   r_col_mem [PAGE_WIDTH];
    logic [HW-1:0]   r_pre_mem [PAGE_WIDTH];
    logic [HW-1:0]   r_col_q;
    logic [HW-1:0]   r_pre_q;

    logic            col_we;
    logic [HW-1:0]   col_wdata;
    logic            pre_we;
    logic [AW-1:0]   pre_raddr;

    // Decoded conditions
    logic            req_take;
    logic            req_bad;
    logic [7:0]      w_m1;
    logic [HW-1:0]   fwd_pm;
    logic [HW-1:0]   bwd_sm;
    logic [HW-1:0]   bwd_top;
    logic            bwd_cand;
    logic            fwd_done;
    logic            bwd_done;
    logic            fits;
    logic            at_limit;
    logic            wr_done;
    logic            clr_done;
    logic            out_load;

    // Decode request and pass conditions
    assign req_take  = i_req.valid && (r_state == S_IDLE);
    assign req_bad   = (i_req.payload.rect_width == 8'd0) ||
                       (i_req.payload.rect_height == 8'd0) ||
                       (32'(i_req.payload.rect_width) >= PAGE_WIDTH) ||
                       (32'(i_req.payload.rect_height) > PAGE_HEIGHT);
    assign w_m1      = r_w - 8'd1;
    assign fwd_pm    = (r_c == 8'd0) ? r_col_q :
                       ((r_col_q > r_run) ? r_col_q : r_run);
    assign bwd_sm    = (r_first || (r_c == w_m1)) ? r_col_q :
                       ((r_col_q > r_run) ? r_col_q : r_run);
    assign bwd_top   = (bwd_sm > r_pre_q) ? bwd_sm : r_pre_q;
    assign bwd_cand  = (32'(r_didx) + 32'(r_w) < PAGE_WIDTH) &&
                       (32'(bwd_top) < PAGE_HEIGHT) &&
                       (!r_found || (bwd_top <= r_best));
    assign fwd_done  = r_dv && (r_didx == LAST_IDX);
    assign bwd_done  = r_dv && (r_didx == '0);
    assign fits      = r_found && (32'(r_best) + 32'(r_h) <= PAGE_HEIGHT);
    assign at_limit  = (32'(r_page) + 32'd1 >= PAGE_LIMIT);
    assign wr_done   = (r_cnt == 8'd1);
    assign clr_done  = (r_idx == LAST_IDX);
    assign out_load  = !r_ovld || o_rsp.ready;
    assign pre_raddr = r_idx + AW'(w_m1);

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_ovld;
    assign o_rsp.payload = r_odata;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    if (i_req.payload.operation == OP_BEGIN) begin
                        n_state = S_CLR;
                    end else if (req_bad) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_FWD;
                    end
                end
            end
            S_FWD: begin
                if (fwd_done) begin
                    n_state = S_BWD;
                end
            end
            S_BWD: begin
                if (bwd_done) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (fits) begin
                    n_state = S_WR;
                end else if (at_limit) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_CLR;
                end
            end
            S_WR: begin
                if (wr_done) begin
                    n_state = S_OUT;
                end
            end
            S_CLR: begin
                if (clr_done) begin
                    n_state = r_clr_out ? S_OUT : S_IDLE;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_idx         = r_idx;
        n_iss         = r_iss;
        n_dv          = 1'b0;
        n_didx        = r_didx;
        n_c           = r_c;
        n_first       = r_first;
        n_run         = r_run;
        n_best        = r_best;
        n_bx          = r_bx;
        n_found       = r_found;
        n_w           = r_w;
        n_h           = r_h;
        n_wval        = r_wval;
        n_cnt         = r_cnt;
        n_page        = r_page;
        n_clr_newpage = r_clr_newpage;
        n_clr_out     = r_clr_out;
        n_res         = r_res;
        n_ovld        = r_ovld && !o_rsp.ready;
        n_odata       = r_odata;
        col_we        = 1'b0;
        col_wdata     = '0;
        pre_we        = 1'b0;

        case (r_state)
            S_IDLE: begin
                // Latch the request and set up the first pass
                if (req_take) begin
                    n_w   = i_req.payload.rect_width;
                    n_h   = i_req.payload.rect_height;
                    n_idx = '0;
                    n_iss = 1'b1;
                    n_c   = 8'd0;
                    if (i_req.payload.operation == OP_BEGIN) begin
                        n_page        = '0;
                        n_clr_newpage = 1'b0;
                        n_clr_out     = 1'b1;
                        n_res         = '{STAT_PLACED, 7'd0, 7'd0, 7'd0};
                    end else begin
                        n_res = '{STAT_NOFIT, 7'd0, 7'd0, 7'(r_page)};
                    end
                end
            end
            S_FWD: begin
                // Issue reads left to right
                if (r_iss) begin
                    n_idx = r_idx + AW'(1);
                    n_iss = (r_idx != LAST_IDX);
                end
                n_dv   = r_iss;
                n_didx = r_idx;
                // Store block prefix maxima
                if (r_dv) begin
                    pre_we = 1'b1;
                    n_run  = fwd_pm;
                    n_c    = (r_c == w_m1) ? 8'd0 : r_c + 8'd1;
                end
                // Turn around, keeping the block position of the last column
                if (fwd_done) begin
                    n_c     = r_c;
                    n_idx   = LAST_IDX;
                    n_iss   = 1'b1;
                    n_dv    = 1'b0;
                    n_first = 1'b1;
                    n_found = 1'b0;
                end
            end
            S_BWD: begin
                // Issue reads right to left
                if (r_iss) begin
                    n_idx = r_idx - AW'(1);
                    n_iss = (r_idx != '0);
                end
                n_dv   = r_iss;
                n_didx = r_idx;
                // Track suffix maxima and keep the lowest window, earliest start
                if (r_dv) begin
                    n_run   = bwd_sm;
                    n_first = 1'b0;
                    n_c     = (r_c == 8'd0) ? w_m1 : r_c - 8'd1;
                    if (bwd_cand) begin
                        n_best  = bwd_top;
                        n_bx    = r_didx;
                        n_found = 1'b1;
                    end
                end
                if (bwd_done) begin
                    n_iss = 1'b0;
                    n_dv  = 1'b0;
                end
            end
            S_DEC: begin
                if (fits) begin
                    n_wval = r_best + HW'(r_h);
                    n_idx  = r_bx;
                    n_cnt  = r_w;
                end else if (at_limit) begin
                    n_res = '{STAT_LIMIT, 7'd0, 7'd0, 7'(r_page)};
                end else begin
                    // Close the page and rebuild the profile with the item at 0
                    n_page        = r_page + PGW'(1);
                    n_idx         = '0;
                    n_clr_newpage = 1'b1;
                    n_clr_out     = 1'b1;
                    n_res         = '{STAT_NEWPAGE, 7'd0, 7'd0, 7'(r_page + PGW'(1))};
                end
            end
            S_WR: begin
                // Raise the chosen columns
                col_we    = 1'b1;
                col_wdata = r_wval;
                n_idx     = r_idx + AW'(1);
                n_cnt     = r_cnt - 8'd1;
                if (wr_done) begin
                    n_res = '{STAT_PLACED, 7'(r_bx), 7'(r_best), 7'(r_page)};
                end
            end
            S_CLR: begin
                // Sweep the profile: zero, or the new item's height on its columns
                col_we    = 1'b1;
                col_wdata = (r_clr_newpage && (32'(r_idx) < 32'(r_w))) ?
                            HW'(r_h) : '0;
                n_idx     = r_idx + AW'(1);
            end
            S_OUT: begin
                // Hand the result to the output register
                if (out_load) begin
                    n_ovld  = 1'b1;
                    n_odata = r_res;
                end
            end
            default: begin
                n_iss = 1'b0;
            end
        endcase
    end

    // Column memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (col_we) begin
            r_col_mem[r_idx] <= col_wdata;
        end
        r_col_q <= r_col_mem[r_idx];
    end

    // Prefix memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (pre_we) begin
            r_pre_mem[r_didx] <= fwd_pm;
        end
        r_pre_q <= r_pre_mem[pre_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_idx         <= '0;
            r_iss         <= 1'b0;
            r_dv          <= 1'b0;
            r_page        <= '0;
            r_clr_newpage <= 1'b0;
            r_clr_out     <= 1'b0;
            r_ovld        <= 1'b0;
            r_found       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_idx         <= n_idx;
            r_iss         <= n_iss;
            r_dv          <= n_dv;
            r_page        <= n_page;
            r_clr_newpage <= n_clr_newpage;
            r_clr_out     <= n_clr_out;
            r_ovld        <= n_ovld;
            r_found       <= n_found;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_didx  <= n_didx;
        r_c     <= n_c;
        r_first <= n_first;
        r_run   <= n_run;
        r_best  <= n_best;
        r_bx    <= n_bx;
        r_w     <= n_w;
        r_h     <= n_h;
        r_wval  <= n_wval;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

    // Checks
    `SKRA_ASSERT_IMPL(a_col_height_range, col_we, 32'(col_wdata) <= PAGE_HEIGHT)
    `SKRA_ASSERT(a_page_below_limit, 32'(r_page) < PAGE_LIMIT)
    `SKRA_ASSERT_IMPL(a_write_needs_found, r_state == S_WR, r_found)
    `SKRA_ASSERT_IMPL(a_write_ends_placed, (r_state == S_OUT) && ($past(r_state) == S_WR), r_res.status == STAT_PLACED)

endmodule
